[rtl/core/aes_pkg.sv]
// Shared types, constants and byte functions for the AES-128 core.
`default_nettype none
package aes_pkg;

	localparam int NumRounds = 10;
	localparam int NumWords  = 44;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_INIT,
		ST_ROUND,
		ST_DONE
	} aes_state_t;

	typedef enum logic [0:0] {
		REG_KEY_HIGH = 1'b0,
		REG_KEY_LOW  = 1'b1
	} aes_reg_t;

	typedef struct packed {
		logic       load;
		logic       exp_start;
		logic       exp_step;
		logic       init_add;
		logic       round_step;
		logic       last;
		logic       store;
		logic [3:0] round;
	} aes_cmd_t;

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		sbox = t[a];
	endfunction

	function automatic logic [7:0] inv_sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
		inv_sbox = t[a];
	endfunction

endpackage
`default_nettype wire

[rtl/core/aes_ctrl.sv]
// Controller state machine for the AES-128 core: sequences expansion and rounds.
`default_nettype none
module aes_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	input  wire logic            key_write,
	output aes_pkg::aes_cmd_t    cmd
);
	import aes_pkg::*;

	aes_state_t state_q, state_d;
	logic [3:0] cnt_q, cnt_d;
	logic       sched_ready_q;
	logic       out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			sched_ready_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
			if (key_write)
				sched_ready_q <= 1'b0;
			else if (state_q == ST_EXPAND && cnt_q == 4'(NumRounds))
				sched_ready_q <= 1'b1;
		end
	end

	always_comb begin
		state_d        = state_q;
		cnt_d          = cnt_q;
		out_valid_d    = out_valid_q;
		cmd            = '0;
		cmd.round      = cnt_q;
		in_ready       = 1'b0;
		if (out_valid_q && out_ready)
			out_valid_d = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				// a finished item may still wait in the output register
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (sched_ready_q) begin
						state_d = ST_INIT;
					end else begin
						cmd.exp_start = 1'b1;
						cnt_d   = 4'd1;
						state_d = ST_EXPAND;
					end
				end
			end
			ST_EXPAND: begin
				// one round key (four words) per cycle
				cmd.exp_step = 1'b1;
				if (cnt_q == 4'(NumRounds))
					state_d = ST_INIT;
				else
					cnt_d = cnt_q + 4'd1;
			end
			ST_INIT: begin
				cmd.init_add = 1'b1;
				cnt_d   = 4'd1;
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round_step = 1'b1;
				cmd.last       = (cnt_q == 4'(NumRounds));
				if (cmd.last) begin
					state_d = ST_DONE;
				end else begin
					cnt_d = cnt_q + 4'd1;
				end
			end
			ST_DONE: begin
				// hold the result until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.round   = 4'(NumRounds);
					cmd.store   = 1'b1;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_IDLE) else $error("accept while busy");
	a_ten_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND |-> cnt_q >= 4'd1 && cnt_q <= 4'(NumRounds))
		else $error("round count out of range");
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.last |=> state_q == ST_DONE) else $error("last round lost");
	a_init_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INIT && !$past(key_write) |-> sched_ready_q)
		else $error("rounds without schedule");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |-> !out_valid_q || out_ready)
		else $error("result overwritten while waiting");
endmodule
`default_nettype wire

[rtl/core/aes_datapath.sv]
// Datapath of the AES-128 core: key registers, schedule memory and round logic.
`default_nettype none
module aes_datapath (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire aes_pkg::aes_cmd_t cmd,
	input  wire logic            cfg_we,
	input  wire logic            cfg_sel,
	input  wire logic [63:0]     cfg_data,
	input  wire logic            mode,
	input  wire logic [63:0]     block_high,
	input  wire logic [63:0]     block_low,
	output logic [63:0]          result_high,
	output logic [63:0]          result_low
);
	import aes_pkg::*;

	logic [63:0]  key_high_q, key_low_q;
	logic [127:0] rk_mem [NumRounds+1];
	logic [127:0] exp_q;
	logic [7:0]   rcon_q;
	logic [127:0] state_q;
	logic         dec_q;
	logic [127:0] rk;
	logic [127:0] exp_next;
	logic [127:0] round_out;
	logic [3:0]   rk_idx;
	logic [63:0]  res_hi_q, res_lo_q;

	// next round key from the previous one
	always_comb begin
		logic [31:0] w3, t;
		w3 = exp_q[31:0];
		t = {sbox(w3[23:16]), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])}
			^ {rcon_q, 24'h0};
		exp_next[127:96] = exp_q[127:96] ^ t;
		exp_next[95:64]  = exp_q[95:64] ^ exp_next[127:96];
		exp_next[63:32]  = exp_q[63:32] ^ exp_next[95:64];
		exp_next[31:0]   = exp_q[31:0]  ^ exp_next[63:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_we) begin
			if (cfg_sel == REG_KEY_HIGH) key_high_q <= cfg_data;
			else key_low_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exp_start) begin
			exp_q  <= {key_high_q, key_low_q};
			rcon_q <= 8'h01;
			rk_mem[0] <= {key_high_q, key_low_q};
		end else if (cmd.exp_step) begin
			exp_q  <= exp_next;
			rcon_q <= xtime(rcon_q);
			rk_mem[cmd.round] <= exp_next;
		end
	end

	// encryption walks keys upward, decryption downward
	always_comb begin
		if (cmd.init_add)
			rk_idx = dec_q ? 4'(NumRounds) : 4'd0;
		else
			rk_idx = dec_q ? 4'(NumRounds) - cmd.round : cmd.round;
	end
	assign rk = rk_mem[rk_idx];

	always_comb begin
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] m [16];
		logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3;
		logic [7:0] b0, b1, b2, b3;
		{x0, x1, x2, x3, b0, b1, b2, b3} = '0;
		for (int i = 0; i < 16; i++) s[i] = state_q[127-8*i -: 8];
		if (!dec_q) begin
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					t[c*4+r] = sbox(s[((c+r)%4)*4+r]);
			for (int c = 0; c < 4; c++) begin
				a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
				m[c*4]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
				m[c*4+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
				m[c*4+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
				m[c*4+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
			end
			for (int i = 0; i < 16; i++)
				round_out[127-8*i -: 8] = (cmd.last ? t[i] : m[i]) ^ rk[127-8*i -: 8];
		end else begin
			// round = inverse shift/sub, add key, inverse mix (skipped on last)
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					t[((c+r)%4)*4+r] = inv_sbox(s[c*4+r]);
			for (int i = 0; i < 16; i++) t[i] = t[i] ^ rk[127-8*i -: 8];
			for (int c = 0; c < 4; c++) begin
				a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
				x0 = xtime(a0); x1 = xtime(a1); x2 = xtime(a2); x3 = xtime(a3);
				b0 = xtime(x0); b1 = xtime(x1); b2 = xtime(x2); b3 = xtime(x3);
				// 9 = 8+1, 11 = 8+2+1, 13 = 8+4+1, 14 = 8+4+2
				m[c*4]   = (xtime(b0)^b0^x0) ^ (xtime(b1)^x1^a1)
					^ (xtime(b2)^b2^a2) ^ (xtime(b3)^a3);
				m[c*4+1] = (xtime(b0)^a0) ^ (xtime(b1)^b1^x1)
					^ (xtime(b2)^x2^a2) ^ (xtime(b3)^b3^a3);
				m[c*4+2] = (xtime(b0)^b0^a0) ^ (xtime(b1)^a1)
					^ (xtime(b2)^b2^x2) ^ (xtime(b3)^x3^a3);
				m[c*4+3] = (xtime(b0)^x0^a0) ^ (xtime(b1)^b1^a1)
					^ (xtime(b2)^a2) ^ (xtime(b3)^b3^x3);
			end
			for (int i = 0; i < 16; i++)
				round_out[127-8*i -: 8] = cmd.last ? t[i] : m[i];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			state_q <= {block_high, block_low};
			dec_q   <= mode;
		end else if (cmd.init_add) begin
			state_q <= state_q ^ rk;
		end else if (cmd.round_step) begin
			state_q <= round_out;
		end
		if (cmd.store) begin
			res_hi_q <= state_q[127:64];
			res_lo_q <= state_q[63:0];
		end
	end

	assign result_high = res_hi_q;
	assign result_low  = res_lo_q;
endmodule
`default_nettype wire

[rtl/core/aes128_block_cipher.sv]
// Top level of the AES-128 core: controller plus datapath.
// An accepted item runs the initial key add, the rounds and the store of the result;
// after a key write it first expands the schedule, one round key per cycle.
// A new item is accepted only once the previous one has left the single shared round unit.
// Reset clears control state and the key registers; the round-key store is
// rebuilt on first use.
`default_nettype none
module aes128_block_cipher (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        mode,
	input  wire logic [63:0] block_high,
	input  wire logic [63:0] block_low,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      result_high,
	output logic [63:0]      result_low
);
	import aes_pkg::*;

	aes_cmd_t cmd;

	aes_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.key_write (cfg_we),
		.cmd       (cmd)
	);

	aes_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_we),
		.cfg_sel     (cfg_index[0]),
		.cfg_data    (cfg_data),
		.mode        (mode),
		.block_high  (block_high),
		.block_low   (block_low),
		.result_high (result_high),
		.result_low  (result_low)
	);
endmodule
`default_nettype wire
